@@ sv/plm_pkg.sv @@
// Shared codes and types for the pooled linked list manager.
`timescale 1ns / 1ps

package plm_pkg;

   localparam int KindWidth   = 2;
   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 2;

   localparam logic [KindWidth-1:0] KIND_INSERT = 2'd0;
   localparam logic [KindWidth-1:0] KIND_SEARCH = 2'd1;
   localparam logic [KindWidth-1:0] KIND_DELETE = 2'd2;

   localparam logic [StatusWidth-1:0] STATUS_OK        = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_NO_MEMORY = 2'd2;

   typedef logic signed [ValueWidth-1:0] value_type;

   // One request traveling down the row of cells.
   typedef struct packed {
      logic                 active;
      logic [KindWidth-1:0] kind;
      value_type            value;
      logic                 hit;
   } token_type;

   // What one cell holds; the left neighbor reads it when a delete closes the gap.
   typedef struct packed {
      logic      valid;
      value_type data;
   } cell_state_type;

endpackage

@@ sv/plm_channels.sv @@
// Handshake channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface plm_req_if
   import plm_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] kind;
   value_type            item_value;

   modport source (output valid, output kind, output item_value, input ready);
   modport sink   (input valid, input kind, input item_value, output ready);
endinterface

interface plm_rsp_if
   import plm_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [StatusWidth-1:0] status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

@@ sv/pooled_linked_list_manager.sv @@
// Top level of the pooled linked list manager: a row of value cells.
//
//   channel   direction   payload              beat when
//   req_chan  in          kind, item_value     valid && ready
//   rsp_chan  out         status               valid && ready
//
// Each request runs down the row of CAPACITY cells, one cell per cycle; its
// status goes into the output register once it has left the last cell.
// One request is in the row at a time; the next one is taken as soon as the
// row is empty and the previous response is leaving or gone.
// Reset (synchronous) empties the list; cell contents need no clearing.
// A stalled response holds in its output register and only holds off requests.
`timescale 1ns / 1ps

module pooled_linked_list_manager
   import plm_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input logic     clock,
   input logic     reset,
   plm_req_if.sink   req_chan,
   plm_rsp_if.source rsp_chan
);

   token_type      tok [CAPACITY+1];
   cell_state_type cell_st [CAPACITY+1];

   logic                   busy_ff, busy_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [StatusWidth-1:0] status_ff, status_in;
   logic                   req_beat;
   token_type              tail_tok;

   assign req_chan.ready = !busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_beat       = req_chan.valid && req_chan.ready;

   assign tok[0].active = req_beat;
   assign tok[0].kind   = req_chan.kind;
   assign tok[0].value  = req_chan.item_value;
   assign tok[0].hit    = 1'b0;

   // Past the last cell the row reads as empty.
   assign cell_st[CAPACITY] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      plm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (tok[i]),
         .right_st (cell_st[i+1]),
         .tok_out  (tok[i+1]),
         .cell_st  (cell_st[i])
      );
   end

   assign tail_tok = tok[CAPACITY];

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_beat) begin
         busy_in = 1'b1;
      end
      if (tail_tok.active) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         case (tail_tok.kind)
            KIND_INSERT: status_in = tail_tok.hit ? STATUS_OK : STATUS_NO_MEMORY;
            KIND_SEARCH: status_in = tail_tok.hit ? STATUS_OK : STATUS_NOT_FOUND;
            KIND_DELETE: status_in = tail_tok.hit ? STATUS_OK : STATUS_NOT_FOUND;
            default:     status_in = STATUS_NOT_FOUND;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;

endmodule

@@ sv/plm_cell.sv @@
// One list cell: holds one value and processes the request token passing by.
`timescale 1ns / 1ps

module plm_cell
   import plm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  token_type      tok_in,
   input  cell_state_type right_st,
   output token_type      tok_out,
   output cell_state_type cell_st
);

   logic      valid_ff, valid_in;
   value_type data_ff, data_in;
   token_type tok_ff, tok_in_next;
   logic      match;

   assign match = valid_ff && (data_ff == tok_in.value);

   always_comb begin
      valid_in    = valid_ff;
      data_in     = data_ff;
      tok_in_next = tok_in;
      if (tok_in.active) begin
         case (tok_in.kind)
            KIND_INSERT: begin
               // The list is kept packed from cell zero, so the first empty cell is the tail.
               if (!tok_in.hit && !valid_ff) begin
                  valid_in        = 1'b1;
                  data_in         = tok_in.value;
                  tok_in_next.hit = 1'b1;
               end
            end
            KIND_SEARCH: begin
               if (match) begin
                  tok_in_next.hit = 1'b1;
               end
            end
            KIND_DELETE: begin
               // From the first match onward every cell pulls in its right neighbor.
               if (tok_in.hit || match) begin
                  valid_in        = right_st.valid;
                  data_in         = right_st.data;
                  tok_in_next.hit = 1'b1;
               end
            end
            default: begin
               tok_in_next.hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         tok_ff.active <= tok_in_next.active;
      end
      data_ff     <= data_in;
      tok_ff.kind  <= tok_in_next.kind;
      tok_ff.value <= tok_in_next.value;
      tok_ff.hit   <= tok_in_next.hit;
   end

   assign tok_out       = tok_ff;
   assign cell_st.valid = valid_ff;
   assign cell_st.data  = data_ff;

endmodule
